[rtl/gvc_pkg.sv]
package gvc_pkg;

    localparam int MAX_V = 64;
    localparam int VW    = $clog2(MAX_V);
    localparam int NW    = VW + 1;

    localparam logic CFG_NUM_VERTICES = 1'b0;
    localparam logic CFG_METHOD       = 1'b1;

    localparam logic FUNC_EDGE = 1'b0;
    localparam logic FUNC_RUN  = 1'b1;

    localparam logic METHOD_WP     = 1'b0;
    localparam logic METHOD_GREEDY = 1'b1;

    typedef struct packed {
        logic          func;
        logic [VW-1:0] vertex_a;
        logic [VW-1:0] vertex_b;
    } t_gvc_in;

    typedef struct packed {
        logic [VW-1:0] vertex_index;
        logic [VW-1:0] color;
        logic [NW-1:0] color_count;
        logic          last_vertex;
    } t_gvc_out;

endpackage

[rtl/gvc_ram.sv]
module gvc_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[rtl/graph_vertex_coloring.sv]
// Vertex coloring engine. An edge transfer sets the two symmetric bits of the adjacency matrix
// (rows kept in a 64 x 64 RAM), row a and then row b, with one write for a self-loop and no
// write when an end lies at or beyond the vertex count; busy stays high meanwhile. A run
// transfer colors vertices 0..n-1 and then emits one result per cycle, vertex 0 first,
// last_vertex on the final one; the receiver cannot stall, so results must be taken as they
// appear. Welsh-Powell runs compute degrees, rank the vertices (one RAM read per vertex
// pair), make one pass per color, then output. Greedy runs scan the colors of the lower-indexed
// neighbors of each vertex u and search for the lowest free color, then output. The
// matrix reads as all zero after reset with no clearing pass; configuration ready is low while
// busy or start is high, so registers change only between items.
module graph_vertex_coloring (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  gvc_pkg::t_gvc_in           i_item,
    output logic                       o_strobe,
    output gvc_pkg::t_gvc_out          o_result,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic                       i_cfg_index,
    input  logic [gvc_pkg::NW-1:0]     i_cfg_data
);

    localparam int MV = gvc_pkg::MAX_V;
    localparam int VW = gvc_pkg::VW;
    localparam int NW = gvc_pkg::NW;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_EDGE_A = 12'b0000_0000_0010,
        S_EDGE_B = 12'b0000_0000_0100,
        S_EDGE_W = 12'b0000_0000_1000,
        S_DEG    = 12'b0000_0001_0000,
        S_RANK_V = 12'b0000_0010_0000,
        S_RANK_U = 12'b0000_0100_0000,
        S_WP     = 12'b0000_1000_0000,
        S_GR_U   = 12'b0001_0000_0000,
        S_GR_J   = 12'b0010_0000_0000,
        S_GR_C   = 12'b0100_0000_0000,
        S_OUT    = 12'b1000_0000_0000
    } t_state;

    function automatic logic [NW-1:0] popcnt(input logic [MV-1:0] x);
        logic [NW-1:0] sum;
        logic [3:0]    part;
        sum = '0;
        for (int g = 0; g < MV / 8; g++) begin
            part = '0;
            for (int b = 0; b < 8; b++) begin
                part = part + 4'(x[g*8+b]);
            end
            sum = sum + NW'(part);
        end
        return sum;
    endfunction

    t_state            r_state;
    logic [NW-1:0]     r_num;
    logic              r_method;
    logic [VW-1:0]     r_a;
    logic [VW-1:0]     r_b;
    logic [NW-1:0]     r_cnt;
    logic              r_pv;
    logic [VW-1:0]     r_pidx;
    logic [VW-1:0]     r_v;
    logic [1:0]        r_ph;
    logic [NW-1:0]     r_dv;
    logic [VW-1:0]     r_rank;
    logic [MV-1:0]     r_uncol;
    logic [MV-1:0]     r_hold;
    logic              r_first;
    logic [NW-1:0]     r_color;
    logic [NW-1:0]     r_count;
    logic [MV-1:0]     r_used;
    logic [MV-1:0]     r_nb;
    logic [MV-1:0]     r_row_vld;
    logic              r_adj_vq;
    logic              r_strobe;
    gvc_pkg::t_gvc_out r_res;

    logic          adj_we;
    logic [VW-1:0] adj_waddr, adj_raddr;
    logic [MV-1:0] adj_wdata, adj_rdata;
    logic          deg_we;
    logic [VW-1:0] deg_waddr, deg_raddr;
    logic [NW-1:0] deg_wdata, deg_rdata;
    logic          ord_we;
    logic [VW-1:0] ord_waddr, ord_raddr, ord_wdata, ord_rdata;
    logic          col_we;
    logic [VW-1:0] col_waddr, col_raddr, col_wdata, col_rdata;

    logic [NW-1:0] w_n;
    logic [VW-1:0] w_last_v;
    logic [MV-1:0] w_mask;
    logic [MV-1:0] w_row;
    logic          w_issue;
    logic          w_scan_done;
    logic          w_gj_issue;
    logic          w_gj_done;
    logic          w_take;
    logic [MV-1:0] w_hold_nx;
    logic [MV-1:0] w_uncol_nx;
    logic          w_cr_stop;

    always_comb begin
        if (r_num == '0) begin
            w_n = NW'(1);
        end else if (r_num > NW'(MV)) begin
            w_n = NW'(MV);
        end else begin
            w_n = r_num;
        end
    end

    assign w_last_v = VW'(w_n - NW'(1));

    always_comb begin
        for (int i = 0; i < MV; i++) begin
            w_mask[i] = (NW'(i) < w_n);
        end
    end

    // rows never written read as zero
    assign w_row       = r_adj_vq ? adj_rdata : '0;
    assign w_issue     = (r_cnt < w_n);
    assign w_scan_done = (r_cnt == w_n) && !r_pv;
    assign w_gj_issue  = (r_cnt < {1'b0, r_v});
    assign w_gj_done   = !w_gj_issue && !r_pv;
    assign w_take      = r_uncol[r_v] && (r_first || ((w_row & r_hold & w_mask) == '0));
    assign w_hold_nx   = w_take ? (r_hold | (MV'(1) << r_v)) : r_hold;
    assign w_uncol_nx  = r_uncol & ~w_hold_nx;
    assign w_cr_stop   = !((r_cnt < NW'(MV - 1)) && r_used[r_cnt[VW-1:0]]);

    always_comb begin
        adj_raddr = r_a;
        adj_we    = 1'b0;
        adj_waddr = r_a;
        adj_wdata = w_row | (MV'(1) << r_b);
        deg_raddr = r_cnt[VW-1:0];
        deg_we    = 1'b0;
        deg_waddr = r_pidx;
        deg_wdata = popcnt(w_row & w_mask);
        ord_raddr = r_cnt[VW-1:0];
        ord_we    = 1'b0;
        ord_waddr = r_rank;
        ord_wdata = r_v;
        col_raddr = r_cnt[VW-1:0];
        col_we    = 1'b0;
        col_waddr = r_v;
        col_wdata = r_color[VW-1:0];
        unique case (r_state)
            S_IDLE: begin
                adj_raddr = i_item.vertex_a;
            end
            S_EDGE_A: begin
                adj_raddr = r_a;
            end
            S_EDGE_B: begin
                adj_we    = 1'b1;
                adj_raddr = r_b;
            end
            S_EDGE_W: begin
                adj_we    = 1'b1;
                adj_waddr = r_b;
                adj_wdata = w_row | (MV'(1) << r_a);
            end
            S_DEG: begin
                adj_raddr = r_cnt[VW-1:0];
                deg_we    = r_pv;
            end
            S_RANK_V: begin
                deg_raddr = r_v;
            end
            S_RANK_U: begin
                ord_we = w_scan_done;
            end
            S_WP: begin
                adj_raddr = ord_rdata;
                col_we    = (r_ph == 2'd2) && w_take;
            end
            S_GR_U: begin
                adj_raddr = r_v;
            end
            S_GR_J: begin
                col_raddr = r_cnt[VW-1:0];
            end
            S_GR_C: begin
                col_we    = w_cr_stop;
                col_wdata = r_cnt[VW-1:0];
            end
            S_OUT: begin
                col_raddr = r_cnt[VW-1:0];
            end
            default: begin
                adj_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_num     <= NW'(MV);
            r_method  <= gvc_pkg::METHOD_WP;
            r_row_vld <= '0;
            r_strobe  <= 1'b0;
            r_pv      <= 1'b0;
            r_ph      <= 2'd0;
            r_cnt     <= '0;
        end else begin
            r_strobe <= 1'b0;
            r_adj_vq <= r_row_vld[adj_raddr];

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    gvc_pkg::CFG_NUM_VERTICES: r_num    <= i_cfg_data;
                    gvc_pkg::CFG_METHOD:       r_method <= i_cfg_data[0];
                    default:                   r_method <= r_method;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_a     <= i_item.vertex_a;
                        r_b     <= i_item.vertex_b;
                        r_cnt   <= '0;
                        r_pv    <= 1'b0;
                        r_ph    <= 2'd0;
                        r_v     <= '0;
                        r_count <= NW'(1);
                        if (i_item.func == gvc_pkg::FUNC_RUN) begin
                            r_state <= (r_method == gvc_pkg::METHOD_GREEDY) ? S_GR_U : S_DEG;
                        end else if ((NW'(i_item.vertex_a) < w_n)
                                     && (NW'(i_item.vertex_b) < w_n)) begin
                            r_state <= S_EDGE_A;
                        end
                    end
                end
                S_EDGE_A: begin
                    r_state <= S_EDGE_B;
                end
                S_EDGE_B: begin
                    r_row_vld[r_a] <= 1'b1;
                    // a self-loop is complete with one write
                    r_state <= (r_a == r_b) ? S_IDLE : S_EDGE_W;
                end
                S_EDGE_W: begin
                    r_row_vld[r_b] <= 1'b1;
                    r_state        <= S_IDLE;
                end
                S_DEG: begin
                    if (w_issue) begin
                        r_cnt  <= r_cnt + NW'(1);
                        r_pidx <= r_cnt[VW-1:0];
                        r_pv   <= 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (w_scan_done) begin
                        r_v     <= '0;
                        r_ph    <= 2'd0;
                        r_state <= S_RANK_V;
                    end
                end
                S_RANK_V: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_dv    <= deg_rdata;
                        r_ph    <= 2'd0;
                        r_cnt   <= '0;
                        r_pv    <= 1'b0;
                        r_rank  <= '0;
                        r_state <= S_RANK_U;
                    end
                end
                S_RANK_U: begin
                    if (w_issue) begin
                        r_cnt  <= r_cnt + NW'(1);
                        r_pidx <= r_cnt[VW-1:0];
                        r_pv   <= 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                    // count vertices that come ahead: higher degree, or equal and lower index
                    if (r_pv && ((deg_rdata > r_dv) || ((deg_rdata == r_dv) && (r_pidx < r_v)))) begin
                        r_rank <= r_rank + VW'(1);
                    end
                    if (w_scan_done) begin
                        r_ph <= 2'd0;
                        if (r_v == w_last_v) begin
                            r_uncol <= w_mask;
                            r_hold  <= '0;
                            r_first <= 1'b1;
                            r_color <= '0;
                            r_cnt   <= '0;
                            r_state <= S_WP;
                        end else begin
                            r_v     <= r_v + VW'(1);
                            r_state <= S_RANK_V;
                        end
                    end
                end
                S_WP: begin
                    unique case (r_ph)
                        2'd0: r_ph <= 2'd1;
                        2'd1: begin
                            r_v  <= ord_rdata;
                            r_ph <= 2'd2;
                        end
                        default: begin
                            r_ph <= 2'd0;
                            if (w_take) begin
                                r_first <= 1'b0;
                            end
                            if (r_cnt + NW'(1) == w_n) begin
                                r_uncol <= w_uncol_nx;
                                r_color <= r_color + NW'(1);
                                r_cnt   <= '0;
                                r_hold  <= '0;
                                r_first <= 1'b1;
                                if (w_uncol_nx == '0) begin
                                    r_count <= r_color + NW'(1);
                                    r_pv    <= 1'b0;
                                    r_state <= S_OUT;
                                end
                            end else begin
                                r_hold <= w_hold_nx;
                                r_cnt  <= r_cnt + NW'(1);
                            end
                        end
                    endcase
                end
                S_GR_U: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_nb    <= w_row & w_mask & ((MV'(1) << r_v) - MV'(1));
                        r_used  <= '0;
                        r_cnt   <= '0;
                        r_pv    <= 1'b0;
                        r_ph    <= 2'd0;
                        r_state <= S_GR_J;
                    end
                end
                S_GR_J: begin
                    if (w_gj_issue) begin
                        r_cnt  <= r_cnt + NW'(1);
                        r_pidx <= r_cnt[VW-1:0];
                        r_pv   <= 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv && r_nb[r_pidx]) begin
                        r_used[col_rdata] <= 1'b1;
                    end
                    if (w_gj_done) begin
                        r_cnt   <= '0;
                        r_state <= S_GR_C;
                    end
                end
                S_GR_C: begin
                    if (!w_cr_stop) begin
                        r_cnt <= r_cnt + NW'(1);
                    end else begin
                        if (r_cnt + NW'(1) > r_count) begin
                            r_count <= r_cnt + NW'(1);
                        end
                        r_cnt <= '0;
                        r_pv  <= 1'b0;
                        if (r_v == w_last_v) begin
                            r_state <= S_OUT;
                        end else begin
                            r_v     <= r_v + VW'(1);
                            r_ph    <= 2'd0;
                            r_state <= S_GR_U;
                        end
                    end
                end
                S_OUT: begin
                    if (w_issue) begin
                        r_cnt  <= r_cnt + NW'(1);
                        r_pidx <= r_cnt[VW-1:0];
                        r_pv   <= 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv) begin
                        r_strobe                <= 1'b1;
                        r_res.vertex_index      <= r_pidx;
                        r_res.color             <= col_rdata;
                        r_res.color_count       <= r_count;
                        r_res.last_vertex       <= (r_pidx == w_last_v);
                    end
                    if (w_scan_done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    gvc_ram #(.W(MV), .D(MV)) u_adj_ram (
        .i_clk  (i_clk),
        .i_we   (adj_we),
        .i_waddr(adj_waddr),
        .i_wdata(adj_wdata),
        .i_raddr(adj_raddr),
        .o_rdata(adj_rdata)
    );

    gvc_ram #(.W(NW), .D(MV)) u_deg_ram (
        .i_clk  (i_clk),
        .i_we   (deg_we),
        .i_waddr(deg_waddr),
        .i_wdata(deg_wdata),
        .i_raddr(deg_raddr),
        .o_rdata(deg_rdata)
    );

    gvc_ram #(.W(VW), .D(MV)) u_ord_ram (
        .i_clk  (i_clk),
        .i_we   (ord_we),
        .i_waddr(ord_waddr),
        .i_wdata(ord_wdata),
        .i_raddr(ord_raddr),
        .o_rdata(ord_rdata)
    );

    gvc_ram #(.W(VW), .D(MV)) u_col_ram (
        .i_clk  (i_clk),
        .i_we   (col_we),
        .i_waddr(col_waddr),
        .i_wdata(col_wdata),
        .i_raddr(col_raddr),
        .o_rdata(col_rdata)
    );

    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_result    = r_res;
    // hold register writes off while an item is pending or in flight
    assign o_cfg_ready = (r_state == S_IDLE) && !start;

endmodule

[rtl/gvc_checker.sv]
module gvc_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_strobe,
    input gvc_pkg::t_gvc_out o_result
);

    // results of one run come in consecutive cycles, vertex by vertex
    a_next_vertex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last_vertex |=>
            o_strobe && (o_result.vertex_index == $past(o_result.vertex_index) + 6'd1))
        else $error("result sequence broken");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last_vertex |=> !o_strobe)
        else $error("result after last vertex");

    a_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !$past(o_strobe) |-> o_result.vertex_index == '0)
        else $error("run does not start at vertex zero");

    a_color_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ({1'b0, o_result.color} < o_result.color_count))
        else $error("color not below color count");

endmodule

bind graph_vertex_coloring gvc_checker u_gvc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_strobe(o_strobe),
    .o_result(o_result)
);
